@@ rtl/lanczos_resample_mixer_core_assert.svh @@
// assertion macros for the resample mixer core
`ifndef LANCZOS_RESAMPLE_MIXER_CORE_ASSERT_SVH
`define LANCZOS_RESAMPLE_MIXER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LRMC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrmc assertion failed");
// next-cycle implication
`define LRMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrmc assertion failed");
`else
`define LRMC_ASSERT_NOW(lbl, ante, cons)
`define LRMC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/lrm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrm_pkg
// shared types and codes for the lanczos resample mixer
// ----------------------------------------------------------------------------
package lrm_pkg;

    typedef enum logic
    {
        MODE_LOAD    = 1'b0,
        MODE_REQUEST = 1'b1
    } mode_t;

    typedef enum logic [2:0]
    {
        CFG_STEP_RATIO   = 3'd0,
        CFG_SRC_CHANNELS = 3'd1,
        CFG_SRC_FRAMES   = 3'd2,
        CFG_MIX_GAIN     = 3'd3,
        CFG_FRAME_LIMIT  = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0]
    {
        ST_IDLE  = 3'd0,
        ST_TAP   = 3'd1,
        ST_DRAIN = 3'd2,
        ST_MIX   = 3'd3,
        ST_FIN   = 3'd4
    } back_state_t;

    typedef struct packed
    {
        logic [23:0] step_ratio;
        logic [3:0]  channels;
        logic [12:0] frames;
        logic [15:0] mix_gain;
        logic [15:0] frame_limit;
    } cfg_t;

    // one queued command: a memory load or a classified request
    typedef struct packed
    {
        logic        is_load;
        logic        ok;
        logic [12:0] base;
        logic [15:0] frac;
        logic [2:0]  ch;
        logic [15:0] value;
        logic [11:0] addr;
    } cmd_t;

    typedef struct packed
    {
        logic busy;
    } back_status_t;

endpackage
`default_nettype wire

@@ rtl/lrm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrm_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
module lrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/lrm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrm_front
// accepts transactions, forms the source position and classifies requests
// ----------------------------------------------------------------------------
module lrm_front #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          mode,
    input  wire logic [11:0]   load_address,
    input  wire logic [15:0]   load_sample,
    input  wire logic [15:0]   out_frame,
    input  wire logic [2:0]    out_channel,
    input  wire logic [15:0]   prior_value,
    input  wire lrm_pkg::cfg_t cfg,
    output logic               push_valid,
    output lrm_pkg::cmd_t      push_cmd,
    input  wire logic          push_ready
);
    import lrm_pkg::*;

    logic        s_valid_reg;
    logic        s_valid_next;
    logic        s_mode_reg;
    logic [11:0] s_addr_reg;
    logic [15:0] s_value_reg;
    logic [15:0] s_frame_reg;
    logic [2:0]  s_ch_reg;
    logic [39:0] s_pos_reg;
    logic        accept;
    logic        frame_ok;
    logic        bound_ok;
    logic        chan_ok;
    logic        max_ok;

    assign in_ready = !s_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (accept)
        begin
            s_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            s_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
        end
    end

    // position product is registered before the bound check
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_mode_reg  <= mode;
            s_addr_reg  <= load_address;
            s_value_reg <= (mode == MODE_REQUEST) ? prior_value : load_sample;
            s_frame_reg <= out_frame;
            s_ch_reg    <= out_channel;
            s_pos_reg   <= 40'(out_frame) * 40'(cfg.step_ratio);
        end
    end

    assign frame_ok = s_frame_reg < cfg.frame_limit;
    assign bound_ok = ({1'b0, s_pos_reg} + {17'b0, cfg.step_ratio})
                      <= {12'b0, cfg.frames, 16'h0000};
    assign chan_ok  = {1'b0, s_ch_reg} < cfg.channels;
    assign max_ok   = {1'b0, cfg.channels} <= 5'(MAX_CHANNELS);

    always_comb
    begin
        push_valid       = s_valid_reg;
        push_cmd.is_load = (s_mode_reg == MODE_LOAD);
        push_cmd.ok      = frame_ok && bound_ok && chan_ok && max_ok;
        push_cmd.base    = s_pos_reg[28:16];
        push_cmd.frac    = s_pos_reg[15:0];
        push_cmd.ch      = s_ch_reg;
        push_cmd.value   = s_value_reg;
        push_cmd.addr    = s_addr_reg;
    end

endmodule
`default_nettype wire

@@ rtl/lrm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrm_queue
// two entry command queue between front and back
// ----------------------------------------------------------------------------
module lrm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    input  wire lrm_pkg::cmd_t push_cmd,
    output logic               push_ready,
    output logic               pop_valid,
    output lrm_pkg::cmd_t      pop_cmd,
    input  wire logic          pop
);
    import lrm_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/lrm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrm_back
// executes loads, runs the tap loop, mix and saturation of valid requests and passes others through
// ----------------------------------------------------------------------------
module lrm_back #(
    parameter int HALF_TAPS    = 3,
    parameter int SOURCE_DEPTH = 4096,
    parameter int PHASES       = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lrm_pkg::cfg_t      cfg,
    input  wire logic               pop_valid,
    input  wire lrm_pkg::cmd_t      pop_cmd,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      mixed_sample,
    output logic                    in_range,
    output lrm_pkg::back_status_t   status
);
    import lrm_pkg::*;

    localparam int TAP_COUNT = 2 * HALF_TAPS;
    localparam int KW        = $clog2(TAP_COUNT);
    localparam int PW        = $clog2(PHASES);
    localparam int PPW       = 16 + $clog2(PHASES + 1);
    localparam int ROM_DEPTH = PHASES * TAP_COUNT;
    localparam int RIW       = $clog2(ROM_DEPTH);
    localparam int AW        = $clog2(SOURCE_DEPTH);
    localparam int PROD_W    = 33;
    localparam int ACC_W     = PROD_W + KW + 1;
    localparam int SC_W      = ACC_W + 17;
    localparam int TOT_W     = SC_W + 1;

    localparam logic [63:0] Q30_ONE    = 64'd1073741824;
    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [63:0] PI2_Q20    = 64'd10349030;
    localparam logic [16:0] CENTRE_ONE = 17'd32768;
    localparam logic [63:0] SERIES_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'(32767);
    localparam logic signed [TOT_W-1:0] SAT_LO = TOT_W'(-32768);
    localparam logic signed [TOT_W-1:0] TRUNC_BIAS = TOT_W'(64'h3FFF_FFFF);

    typedef logic signed [16:0] rom_t [ROM_DEPTH];

    // elaboration-time shift and subtract divide
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(pi*n/m) in q30
    function automatic longint sin_q30(input longint n, input longint m);
        logic [63:0] mu;
        logic [63:0] span;
        logic [63:0] r;
        logic [63:0] th;
        logic [63:0] t2;
        logic [63:0] acc;
        logic [63:0] s;
        logic        neg;
        mu   = 64'(m);
        span = mu << 1;
        r    = 64'(n + 2 * m * longint'(HALF_TAPS + 1));
        r    = r - span * udiv64(r, span);
        neg  = 1'b0;
        if (r >= mu)
        begin
            neg = 1'b1;
            r   = r - mu;
        end
        if ((r << 1) > mu)
        begin
            r = mu - r;
        end
        th  = udiv64(r * PI_Q30 + (mu >> 1), mu);
        t2  = (th * th) >> 30;
        acc = Q30_ONE;
        for (int k = 0; k < 5; k++)
        begin
            acc = Q30_ONE - udiv64((t2 * acc) >> 30, SERIES_DIV[k]);
        end
        s = (th * acc) >> 30;
        return neg ? -longint'(s) : longint'(s);
    endfunction

    function automatic logic signed [16:0] kernel_weight(input longint d);
        longint      sa;
        longint      sb;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] ad;
        logic [63:0] c;
        logic        neg;
        if (d == 0)
        begin
            return CENTRE_ONE;
        end
        sa  = sin_q30(d, longint'(PHASES));
        sb  = sin_q30(d, longint'(HALF_TAPS) * longint'(PHASES));
        neg = (sa < 0) != (sb < 0);
        ua  = (sa < 0) ? 64'(-sa) : 64'(sa);
        ub  = (sb < 0) ? 64'(-sb) : 64'(sb);
        q   = (ua * ub) >> 30;
        num = 64'(HALF_TAPS) * 64'(PHASES) * 64'(PHASES) * q * 64'd32;
        ad  = (d < 0) ? 64'(-d) : 64'(d);
        den = PI2_Q20 * ad * ad;
        c   = udiv64(num + (den >> 1), den);
        return neg ? -17'(c) : 17'(c);
    endfunction

    function automatic rom_t build_rom();
        rom_t rom;
        for (int p = 0; p < PHASES; p++)
        begin
            for (int k = 0; k < TAP_COUNT; k++)
            begin
                rom[p * TAP_COUNT + k] = kernel_weight(longint'(p)
                    - longint'(k - HALF_TAPS + 1) * longint'(PHASES));
            end
        end
        return rom;
    endfunction

    localparam rom_t KERNEL_ROM = build_rom();

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [KW-1:0]             k_reg;
    logic [KW-1:0]             k_next;
    logic                      drain_reg;
    logic                      drain_next;
    logic                      tap_vld_reg;
    logic                      tap_vld_next;
    logic                      prod_vld_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [12:0]               base_reg;
    logic [2:0]                ch_reg;
    logic signed [15:0]        prior_reg;
    logic [PW-1:0]             phase_reg;
    logic signed [16:0]        rom_q_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [SC_W-1:0]    scaled_reg;
    logic signed [15:0]        mixed_reg;
    logic                      in_range_reg;

    logic                      out_free;
    logic                      ram_we;
    logic                      start;
    logic                      out_load;
    logic                      out_pass;
    logic [PPW-1:0]            phase_prod;
    logic [RIW-1:0]            rom_idx;
    logic signed [14:0]        tap_j;
    logic [18:0]               tap_addr;
    logic                      tap_ok;
    logic [15:0]               ram_rdata;
    logic signed [TOT_W-1:0]   total;
    logic signed [TOT_W-1:0]   shifted;
    logic signed [15:0]        sat_val;

    assign out_free   = !out_valid_reg || out_ready;
    assign phase_prod = PPW'(pop_cmd.frac) * PPW'(PHASES);
    assign rom_idx    = RIW'(RIW'(phase_reg) * RIW'(TAP_COUNT) + RIW'(k_reg));

    // tap frame index, offset from the centre frame by the tap number
    assign tap_j    = $signed({2'b00, base_reg}) + $signed(15'(k_reg))
                      - $signed(15'(HALF_TAPS - 1));
    assign tap_addr = 19'(tap_j[13:0]) * 19'(cfg.channels) + 19'(ch_reg);
    assign tap_ok   = !tap_j[14] && (tap_j[13:0] < {1'b0, cfg.frames})
                      && (tap_addr < 19'(SOURCE_DEPTH));

    lrm_ram #(
        .WIDTH (16),
        .DEPTH (SOURCE_DEPTH)
    ) u_src_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(pop_cmd.addr)),
        .wdata (pop_cmd.value),
        .raddr (tap_addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && !pop_cmd.is_load && pop_cmd.ok)
                begin
                    state_next = ST_TAP;
                end
            end
            ST_TAP:
            begin
                if (k_reg == KW'(TAP_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop      = 1'b0;
        ram_we   = 1'b0;
        start    = 1'b0;
        out_load = 1'b0;
        out_pass = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    if (pop_cmd.is_load)
                    begin
                        pop    = 1'b1;
                        ram_we = {5'b0, pop_cmd.addr} < 17'(SOURCE_DEPTH);
                    end
                    else if (!pop_cmd.ok)
                    begin
                        pop      = out_free;
                        out_load = out_free;
                        out_pass = 1'b1;
                    end
                    else
                    begin
                        pop   = 1'b1;
                        start = 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        k_next         = (state_reg == ST_TAP) ? k_reg + KW'(1) : '0;
        drain_next     = (state_reg == ST_DRAIN) ? !drain_reg : 1'b0;
        tap_vld_next   = (state_reg == ST_TAP) && tap_ok;
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            drain_reg     <= 1'b0;
            tap_vld_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            drain_reg     <= drain_next;
            tap_vld_reg   <= tap_vld_next;
            prod_vld_reg  <= tap_vld_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // saturating mix, truncated toward zero
    always_comb
    begin
        total   = TOT_W'(scaled_reg) + (TOT_W'(prior_reg) <<< 30);
        shifted = (total + (total[TOT_W-1] ? TRUNC_BIAS : TOT_W'(0))) >>> 30;
        if (shifted > SAT_HI)
        begin
            sat_val = 16'sh7FFF;
        end
        else if (shifted < SAT_LO)
        begin
            sat_val = 16'sh8000;
        end
        else
        begin
            sat_val = shifted[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= KERNEL_ROM[rom_idx];
        prod_reg  <= $signed(ram_rdata) * rom_q_reg;
        if (start)
        begin
            base_reg  <= pop_cmd.base;
            ch_reg    <= pop_cmd.ch;
            prior_reg <= $signed(pop_cmd.value);
            phase_reg <= phase_prod[16 +: PW];
            acc_reg   <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (state_reg == ST_MIX)
        begin
            scaled_reg <= acc_reg * $signed({1'b0, cfg.mix_gain});
        end
        if (out_load)
        begin
            mixed_reg    <= out_pass ? $signed(pop_cmd.value) : sat_val;
            in_range_reg <= !out_pass;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = mixed_reg;
    assign in_range     = in_range_reg;
    assign status.busy  = state_reg != ST_IDLE;

endmodule
`default_nettype wire

@@ rtl/lanczos_resample_mixer_core.sv @@
// a computed request passes the front register, the queue, the tap loop, drain, mix and
//   the output register; a pass-through request goes from the queue to the output register
// the back end takes no new command until a computed request reaches the output register,
//   its taps share one source memory read port and multiply-accumulate; idle, it loads one per cycle
// reset: configuration returns to its defaults, the source memory is not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// lanczos_resample_mixer_core
// lanczos resampler with mix and saturation, front/back split by a queue
// ----------------------------------------------------------------------------
`include "lanczos_resample_mixer_core_assert.svh"
module lanczos_resample_mixer_core #(
    parameter int HALF_TAPS    = 3,
    parameter int SOURCE_DEPTH = 4096,
    parameter int MAX_CHANNELS = 8,
    parameter int PHASES       = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic [11:0]        load_address,
    input  wire logic signed [15:0] load_sample,
    input  wire logic [15:0]        out_frame,
    input  wire logic [2:0]         out_channel,
    input  wire logic signed [15:0] prior_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      mixed_sample,
    output logic                    in_range,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);
    import lrm_pkg::*;

    cfg_t         cfg_reg;
    cfg_t         cfg_next;
    cmd_t         push_cmd;
    cmd_t         pop_cmd;
    logic         push_valid;
    logic         push_ready;
    logic         q_valid;
    logic         q_pop;
    back_status_t back_status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_STEP_RATIO:   cfg_next.step_ratio  = cfg_data;
                CFG_SRC_CHANNELS: cfg_next.channels    = cfg_data[3:0];
                CFG_SRC_FRAMES:   cfg_next.frames      = cfg_data[12:0];
                CFG_MIX_GAIN:     cfg_next.mix_gain    = cfg_data[15:0];
                CFG_FRAME_LIMIT:  cfg_next.frame_limit = cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ratio  <= 24'd65536;
            cfg_reg.channels    <= 4'd1;
            cfg_reg.frames      <= 13'd4096;
            cfg_reg.mix_gain    <= 16'd32768;
            cfg_reg.frame_limit <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lrm_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .load_address (load_address),
        .load_sample  (load_sample),
        .out_frame    (out_frame),
        .out_channel  (out_channel),
        .prior_value  (prior_value),
        .cfg          (cfg_reg),
        .push_valid   (push_valid),
        .push_cmd     (push_cmd),
        .push_ready   (push_ready)
    );

    lrm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_cmd    (pop_cmd),
        .pop        (q_pop)
    );

    lrm_back #(
        .HALF_TAPS    (HALF_TAPS),
        .SOURCE_DEPTH (SOURCE_DEPTH),
        .PHASES       (PHASES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .pop_valid    (q_valid),
        .pop_cmd      (pop_cmd),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_sample (mixed_sample),
        .in_range     (in_range),
        .status       (back_status)
    );

    `LRMC_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid)
    `LRMC_ASSERT_NOW(a_pop_only_idle, q_pop, !back_status.busy)
    `LRMC_ASSERT_NEXT(a_queue_keeps, q_valid && !q_pop, q_valid)

endmodule
`default_nettype wire

@@ tb/lanczos_resample_mixer_core_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lanczos_resample_mixer_core_test
// loads a shadow of the source memory and checks every mixed output against an in-bench
// lanczos interpolator or a directed expectation, over directed rows and random phases
// ----------------------------------------------------------------------------
module lanczos_resample_mixer_core_test;
    import lrm_pkg::*;

    localparam int  TAPS_HALF   = 3;
    localparam int  TAP_TOTAL   = 2 * TAPS_HALF;
    localparam int  PHASE_COUNT = 64;
    localparam int  MEM_DEPTH   = 4096;
    localparam int  CH_MAX      = 8;
    localparam int  PRELOAD     = 256;
    localparam int  SETTLE      = 2 * TAPS_HALF + 14;
    localparam int  HOLD_AT     = 100;
    localparam int  HOLD_LEN    = 300;
    localparam longint CYCLE_LIMIT = 600000;
    localparam longint unsigned Q30_UNIT = 64'd1073741824;

    typedef enum logic [1:0]
    {
        ROW_LOAD,
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct
    {
        row_kind_t          kind;
        logic [11:0]        addr;
        logic signed [15:0] sample;
        logic [15:0]        frame;
        logic [2:0]         ch;
        logic signed [15:0] prior;
        cfg_index_t         reg_sel;
        logic [23:0]        reg_val;
        bit                 typed;
        logic signed [15:0] want_sample;
        logic               want_range;
    } stim_row_t;

    typedef struct
    {
        logic signed [15:0] sample;
        logic               flag;
    } mix_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               mode;
    logic [11:0]        load_address;
    logic signed [15:0] load_sample;
    logic [15:0]        out_frame;
    logic [2:0]         out_channel;
    logic signed [15:0] prior_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] mixed_sample;
    logic               in_range;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;

    lanczos_resample_mixer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .load_address (load_address),
        .load_sample  (load_sample),
        .out_frame    (out_frame),
        .out_channel  (out_channel),
        .prior_value  (prior_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_sample (mixed_sample),
        .in_range     (in_range),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // shadow state
    int                 kernel_q15 [PHASE_COUNT][TAP_TOTAL];
    logic [15:0]        src_shadow [MEM_DEPTH];
    bit                 written [MEM_DEPTH];
    logic [23:0]        sh_step;
    logic [3:0]         sh_channels;
    logic [12:0]        sh_frames;
    logic [15:0]        sh_gain;
    logic [15:0]        sh_limit;

    mix_result_t        pending_mix[$];
    stim_row_t          dir_rows[$];
    int                 mismatches;
    int                 results_seen;
    longint             cycles;
    int                 hold_left;
    int                 stall_left;
    bit                 hold_done;
    bit                 gap_free;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("lanczos_resample_mixer_core: mismatch");
            $finish;
        end
    end

    // sin(pi*n/m) in signed q30, polynomial series
    function automatic longint sine_q30(longint n, longint m);
        longint            span;
        longint            r;
        bit                neg;
        longint unsigned   mu;
        longint unsigned   th;
        longint unsigned   t2;
        longint unsigned   acc;
        longint unsigned   s;
        int unsigned       divs [5];
        divs = '{110, 72, 42, 20, 6};
        span = 2 * m;
        r    = n % span;
        neg  = 1'b0;
        if (r < 0)
            r += span;
        if (r >= m)
        begin
            neg = 1'b1;
            r -= m;
        end
        if (2 * r > m)
            r = m - r;
        mu  = longint'(m);
        th  = (longint'(r) * 64'd3373259426 + mu / 2) / mu;
        t2  = (th * th) >> 30;
        acc = Q30_UNIT;
        for (int k = 0; k < 5; k++)
            acc = Q30_UNIT - ((t2 * acc) >> 30) / divs[k];
        s = (th * acc) >> 30;
        return neg ? -longint'(s) : longint'(s);
    endfunction

    function automatic int lanczos_weight(longint d);
        longint            sa;
        longint            sb;
        longint unsigned   ua;
        longint unsigned   ub;
        longint unsigned   q;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   ad;
        longint unsigned   c;
        bit                neg;
        if (d == 0)
            return 32768;
        sa  = sine_q30(d, PHASE_COUNT);
        sb  = sine_q30(d, TAPS_HALF * PHASE_COUNT);
        neg = (sa < 0) != (sb < 0);
        ua  = (sa < 0) ? -sa : sa;
        ub  = (sb < 0) ? -sb : sb;
        q   = (ua * ub) >> 30;
        num = longint'(TAPS_HALF * PHASE_COUNT * PHASE_COUNT) * q * 32;
        ad  = (d < 0) ? -d : d;
        den = 64'd10349030 * ad * ad;
        c   = (num + den / 2) / den;
        return neg ? -int'(c) : int'(c);
    endfunction

    function automatic bit frame_ok(logic [15:0] f, logic [2:0] ch);
        longint unsigned span_end;
        span_end = (longint'(f) + 1) * longint'(sh_step);
        return (f < sh_limit) && (span_end <= (longint'(sh_frames) << 16))
            && (ch < sh_channels) && (sh_channels <= CH_MAX);
    endfunction

    // true if a computed request would tap a slot that was never loaded
    function automatic bit reads_unwritten(logic [15:0] f, logic [2:0] ch);
        longint unsigned  pos;
        longint unsigned  centre;
        longint           j;
        longint unsigned  a;
        if (!frame_ok(f, ch))
            return 1'b0;
        pos    = longint'(f) * longint'(sh_step);
        centre = pos >> 16;
        for (int k = 0; k < TAP_TOTAL; k++)
        begin
            j = longint'(centre) + k - TAPS_HALF + 1;
            if (j < 0 || j >= longint'(sh_frames))
                continue;
            a = longint'(j) * sh_channels + ch;
            if (a >= MEM_DEPTH)
                continue;
            if (!written[a])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic mix_result_t resample_mix(logic [15:0] f, logic [2:0] ch,
                                                 logic signed [15:0] prior);
        mix_result_t      r;
        longint unsigned  pos;
        longint unsigned  centre;
        longint unsigned  ph;
        longint           j;
        longint unsigned  a;
        longint           acc;
        longint           total;
        longint           val;
        r.sample = prior;
        r.flag   = 1'b0;
        if (!frame_ok(f, ch))
            return r;
        pos    = longint'(f) * longint'(sh_step);
        centre = pos >> 16;
        ph     = ((pos & 64'hFFFF) * PHASE_COUNT) >> 16;
        acc    = 0;
        for (int k = 0; k < TAP_TOTAL; k++)
        begin
            j = longint'(centre) + k - TAPS_HALF + 1;
            if (j < 0 || j >= longint'(sh_frames))
                continue;
            a = longint'(j) * sh_channels + ch;
            if (a >= MEM_DEPTH)
                continue;
            acc += longint'($signed(src_shadow[a])) * kernel_q15[ph][k];
        end
        total = longint'(prior) * longint'(Q30_UNIT) + acc * longint'(sh_gain);
        val   = total / longint'(Q30_UNIT);
        if (val > 32767)
            val = 32767;
        if (val < -32768)
            val = -32768;
        r.sample = val[15:0];
        r.flag   = 1'b1;
        return r;
    endfunction

    // result checking and receiver stalls share one process
    always @(posedge clk or negedge rst_n)
    begin
        mix_result_t exp_mix;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_left  = 0;
            stall_left = 0;
            hold_done  = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_mix.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: sample %0d range %0b",
                                 mixed_sample, in_range);
                end
                else
                begin
                    exp_mix = pending_mix.pop_front();
                    if (mixed_sample !== exp_mix.sample || in_range !== exp_mix.flag)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mixed_sample exp %0d got %0d, in_range exp %0b got %0b",
                                     exp_mix.sample, mixed_sample, exp_mix.flag, in_range);
                    end
                end
            end
            if (results_seen >= HOLD_AT && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!gap_free && $urandom_range(0, 3) == 0)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                         : $urandom_range(1, 3);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // called at a rising edge; returns at the edge where the item is taken or after a gap that follows it
    task automatic send_item(mode_t m, logic [11:0] a, logic signed [15:0] smp,
                             logic [15:0] f, logic [2:0] ch, logic signed [15:0] prior,
                             bit typed, mix_result_t want);
        int gap;
        mode         <= m;
        load_address <= a;
        load_sample  <= smp;
        out_frame    <= f;
        out_channel  <= ch;
        prior_value  <= prior;
        in_valid     <= 1'b1;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        if (m == MODE_LOAD)
        begin
            src_shadow[a] = smp;
            written[a]    = 1'b1;
        end
        else
            pending_mix.push_back(typed ? want : resample_mix(f, ch, prior));
        gap = 0;
        if (!gap_free && $urandom_range(0, 1) == 0)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_STEP_RATIO:   sh_step     = v;
            CFG_SRC_CHANNELS: sh_channels = v[3:0];
            CFG_SRC_FRAMES:   sh_frames   = v[12:0];
            CFG_MIX_GAIN:     sh_gain     = v[15:0];
            CFG_FRAME_LIMIT:  sh_limit    = v[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic void add_load(logic [11:0] a, logic signed [15:0] smp);
        dir_rows.push_back('{ROW_LOAD, a, smp, 16'd0, 3'd0, 16'sd0, CFG_STEP_RATIO,
                             24'd0, 1'b0, 16'sd0, 1'b0});
    endfunction

    function automatic void add_req(logic [15:0] f, logic [2:0] ch, logic signed [15:0] prior,
                                    bit typed);
        dir_rows.push_back('{ROW_REQ, 12'd0, 16'sd0, f, ch, prior, CFG_STEP_RATIO,
                             24'd0, typed, prior, 1'b0});
    endfunction

    function automatic void add_cfg(cfg_index_t idx, logic [23:0] v);
        dir_rows.push_back('{ROW_CFG, 12'd0, 16'sd0, 16'd0, 3'd0, 16'sd0, idx, v,
                             1'b0, 16'sd0, 1'b0});
    endfunction

    initial
    begin
        mix_result_t  want;
        stim_row_t    row;
        logic [23:0]  step_pick [8];
        logic [3:0]   ch_pick [8];
        logic [12:0]  frm_pick [8];
        logic [15:0]  gain_pick [8];
        logic [15:0]  lim_pick [8];
        longint       max_frame;
        longint       f_cap;
        int           ch_span;
        int           dice;
        logic [15:0]  f;
        logic [2:0]   ch;
        logic signed [15:0] prior;
        bit           last_cfg;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_LOAD;
        load_address = '0;
        load_sample  = '0;
        out_frame    = '0;
        out_channel  = '0;
        prior_value  = '0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_STEP_RATIO;
        cfg_data     = '0;
        mismatches   = 0;
        results_seen = 0;
        cycles       = 0;
        gap_free     = 1'b1;
        sh_step      = 24'd65536;
        sh_channels  = 4'd1;
        sh_frames    = 13'd4096;
        sh_gain      = 16'd32768;
        sh_limit     = 16'd0;
        want.sample  = '0;
        want.flag    = 1'b0;
        for (int p = 0; p < PHASE_COUNT; p++)
            for (int k = 0; k < TAP_TOTAL; k++)
                kernel_q15[p][k] = lanczos_weight(longint'(p) - longint'(k - TAPS_HALF + 1)
                                                  * PHASE_COUNT);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a low window and the top frames are loaded; requests that would tap
        // any other unloaded slot are moved to frame zero
        for (int a = 0; a < PRELOAD; a++)
            send_item(MODE_LOAD, a[11:0], 16'($urandom), 16'($urandom), 3'($urandom),
                      16'($urandom), 1'b0, want);
        for (int a = MEM_DEPTH - 3; a < MEM_DEPTH; a++)
            send_item(MODE_LOAD, a[11:0], 16'($urandom), 16'($urandom), 3'($urandom),
                      16'($urandom), 1'b0, want);
        gap_free = 1'b0;

        // directed rows: reset config passes every request through
        add_load(12'd0, -16'sd32768);
        add_load(12'd4095, 16'sd32767);
        add_load(12'd1, 16'sd32767);
        add_req(16'd0, 3'd0, 16'sd32767, 1'b1);
        add_req(16'd65535, 3'd7, -16'sd32768, 1'b1);
        add_req(16'd5, 3'd0, 16'sd0, 1'b1);
        add_cfg(CFG_FRAME_LIMIT, 24'd65535);
        add_cfg(CFG_MIX_GAIN, 24'd65535);
        add_req(16'd0, 3'd0, 16'sd32767, 1'b0);
        add_req(16'd1, 3'd0, -16'sd32768, 1'b0);
        add_req(16'd4095, 3'd0, 16'sd100, 1'b0);
        add_req(16'd4096, 3'd0, -16'sd7, 1'b1);
        add_req(16'd3, 3'd1, 16'sd9, 1'b1);
        add_cfg(CFG_SRC_CHANNELS, 24'd9);
        add_req(16'd2, 3'd0, 16'sd1234, 1'b1);
        add_cfg(CFG_SRC_CHANNELS, 24'd8);
        add_cfg(CFG_STEP_RATIO, 24'd0);
        add_req(16'd65534, 3'd7, -16'sd5, 1'b0);
        add_cfg(CFG_STEP_RATIO, 24'hFFFFFF);
        add_req(16'd15, 3'd3, 16'sd0, 1'b0);
        add_req(16'd16, 3'd3, 16'sd77, 1'b1);
        add_cfg(CFG_MIX_GAIN, 24'd0);
        add_cfg(CFG_SRC_FRAMES, 24'd1);
        add_cfg(CFG_STEP_RATIO, 24'd65536);
        add_req(16'd0, 3'd2, 16'sd321, 1'b0);

        last_cfg = 1'b0;
        foreach (dir_rows[i])
        begin
            row         = dir_rows[i];
            want.sample = row.want_sample;
            want.flag   = row.want_range;
            if (row.kind == ROW_CFG)
            begin
                if (!last_cfg)
                    drain_all();
                write_reg(row.reg_sel, row.reg_val);
            end
            else if (row.kind == ROW_LOAD)
                send_item(MODE_LOAD, row.addr, row.sample, row.frame, row.ch, row.prior,
                          1'b0, want);
            else
                send_item(MODE_REQUEST, row.addr, row.sample, row.frame, row.ch, row.prior,
                          row.typed, want);
            last_cfg = (row.kind == ROW_CFG);
        end

        // random phases, one register setting each
        step_pick = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd0, 24'($urandom_range(1, 200000)),
                      24'd32768, 24'($urandom), 24'd98304};
        ch_pick   = '{4'd2, 4'd1, 4'd8, 4'd3, 4'd9, 4'd0, 4'd15, 4'($urandom_range(1, 8))};
        frm_pick  = '{13'd4096, 13'd4096, 13'd4096, 13'd1, 13'd8191,
                      13'($urandom_range(1, 4096)), 13'd2048, 13'd600};
        gain_pick = '{16'd32768, 16'd65535, 16'd0, 16'($urandom), 16'd65535,
                      16'($urandom), 16'd1, 16'd40000};
        lim_pick  = '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'($urandom),
                      16'd0, 16'd300, 16'd65535};
        for (int ph = 0; ph < 8; ph++)
        begin
            drain_all();
            gap_free = (ph == 2);
            write_reg(CFG_STEP_RATIO, step_pick[ph]);
            write_reg(CFG_SRC_CHANNELS, 24'(ch_pick[ph]));
            write_reg(CFG_SRC_FRAMES, 24'(frm_pick[ph]));
            write_reg(CFG_MIX_GAIN, 24'(gain_pick[ph]));
            write_reg(CFG_FRAME_LIMIT, 24'(lim_pick[ph]));
            max_frame = sh_limit;
            if (sh_step != 0 && ((longint'(sh_frames) << 16) / sh_step) < max_frame)
                max_frame = (longint'(sh_frames) << 16) / sh_step;
            ch_span = (sh_channels >= 1 && sh_channels <= CH_MAX) ? sh_channels : CH_MAX;
            // keep most frames inside the loaded window
            if (sh_step != 0)
            begin
                f_cap = ((longint'(PRELOAD / ch_span - TAPS_HALF - 1) + 1) << 16) / sh_step
                        + 1;
                if (f_cap < max_frame)
                    max_frame = f_cap;
            end
            for (int n = 0; n < 30; n++)
            begin
                dice  = $urandom_range(0, 19);
                prior = ($urandom_range(0, 7) == 0)
                        ? (($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000)
                        : 16'($urandom);
                if (dice < 3)
                    send_item(MODE_LOAD, 12'($urandom), 16'($urandom), 16'($urandom),
                              3'($urandom), 16'($urandom), 1'b0, want);
                else if (dice < 5 || max_frame == 0)
                begin
                    f  = 16'($urandom);
                    ch = 3'($urandom);
                    if (reads_unwritten(f, ch))
                        f = 16'd0;
                    send_item(MODE_REQUEST, 12'($urandom), 16'($urandom), f, ch, prior,
                              1'b0, want);
                end
                else
                begin
                    f  = 16'($urandom_range(0, int'(max_frame - 1)));
                    ch = 3'($urandom_range(0, ch_span - 1));
                    if (reads_unwritten(f, ch))
                        f = 16'd0;
                    send_item(MODE_REQUEST, 12'($urandom), 16'($urandom), f, ch, prior,
                              1'b0, want);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_mix.size() == 0)
            $display("lanczos_resample_mixer_core: match");
        else
            $display("lanczos_resample_mixer_core: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/lrm_pkg.sv
rtl/lrm_ram.sv
rtl/lrm_front.sv
rtl/lrm_queue.sv
rtl/lrm_back.sv
rtl/lanczos_resample_mixer_core.sv
tb/lanczos_resample_mixer_core_test.sv
